>>> hdl/fqd_pkg.sv
// ----------------------------------------------------------------------------
// fqd_pkg
// Shared types, character codes and helpers for the form query decoder.
// ----------------------------------------------------------------------------
package fqd_pkg;

	// Default depth of the result queue (must be at least 2)
	localparam int FIFO_DEPTH = 4;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_PAIR_SEP = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_SEP  = 1'b1;

	// Register reset values
	localparam logic [7:0] PAIR_SEP_RESET = 8'h26;  // '&'
	localparam logic [7:0] KEY_SEP_RESET  = 8'h3d;  // '='

	// Character codes
	localparam logic [7:0] CHR_PLUS    = 8'h2b;
	localparam logic [7:0] CHR_PCT     = 8'h25;
	localparam logic [7:0] CHR_SPACE   = 8'h20;
	localparam logic [7:0] CHR_UPPER_A = 8'h41;
	localparam logic [7:0] CHR_ZERO    = 8'h30;
	localparam logic [7:0] CASE_MASK   = 8'hdf;
	localparam logic [7:0] HEX_TEN     = 8'd10;

	localparam logic [15:0] ENTRY_MAX = 16'hffff;

	// Result kinds
	localparam logic [1:0] KIND_NAME  = 2'd0;
	localparam logic [1:0] KIND_VALUE = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_stream;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  out_byte;
		logic [15:0] entry_number;
		logic        last_of_run;
	} out_item_t;

	// Results produced by one decoded byte, in order
	typedef struct packed {
		logic [1:0] count;
		out_item_t  res0;
		out_item_t  res1;
	} dec_push_t;

	// Unchecked hex nibble, mod 256: the byte is taken as a signed char
	function automatic logic [7:0] nibble(input logic [7:0] c);
		logic [7:0] r;
		if (!c[7] && (c >= CHR_UPPER_A)) begin
			r = (c & CASE_MASK) - (CHR_UPPER_A - HEX_TEN);
		end else begin
			r = c - CHR_ZERO;
		end
		return r;
	endfunction

endpackage

>>> hdl/fqd_decode.sv
// ----------------------------------------------------------------------------
// fqd_decode
// Entry splitting and percent/plus decoding state for one raw byte per cycle
// while advance is high, plus the two separator configuration registers.
// ----------------------------------------------------------------------------
module fqd_decode (
	input  logic                           clk,
	input  logic                           arst_n,
	input  fqd_pkg::in_item_t              item_s1,
	input  logic                           advance,
	input  logic                           cfg_valid,
	input  logic [fqd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [7:0]                     cfg_data,
	output fqd_pkg::dec_push_t             push
);

	// Escape phase codes
	localparam logic [1:0] ESC_NONE = 2'd0;
	localparam logic [1:0] ESC_HIGH = 2'd1;
	localparam logic [1:0] ESC_LOW  = 2'd2;

	logic [7:0]  pair_sep_q;
	logic [7:0]  key_sep_q;
	logic [1:0]  esc_q;
	logic [7:0]  high_digit_q;
	logic        in_value_q;
	logic        entry_open_q;
	logic [15:0] entry_count_q;

	logic [1:0]  esc_d;
	logic [7:0]  high_digit_d;
	logic        in_value_d;
	logic        entry_open_d;
	logic [15:0] entry_count_d;

	logic        have_a;
	logic        have_b;
	fqd_pkg::out_item_t res_a;
	fqd_pkg::out_item_t res_b;
	logic [7:0]  hi_nib;
	logic [7:0]  lo_nib;
	logic [7:0]  esc_byte;
	logic [7:0]  b;

	assign b      = item_s1.in_byte;
	assign hi_nib = fqd_pkg::nibble(high_digit_q);
	assign lo_nib = fqd_pkg::nibble(b);
	assign esc_byte = {hi_nib[3:0], 4'b0000} + lo_nib;

	// Next state and results for the byte in the input register
	always_comb begin
		esc_d         = esc_q;
		high_digit_d  = high_digit_q;
		in_value_d    = in_value_q;
		entry_open_d  = entry_open_q;
		entry_count_d = entry_count_q;
		have_a        = 1'b0;
		have_b        = 1'b0;
		res_a.kind         = {1'b0, in_value_q};
		res_a.out_byte     = b;
		res_a.entry_number = entry_count_q;
		res_a.last_of_run  = 1'b0;
		res_b.kind         = fqd_pkg::KIND_END;
		res_b.out_byte     = 8'h00;
		res_b.entry_number = entry_count_q;
		res_b.last_of_run  = 1'b1;

		if (b == pair_sep_q) begin
			have_a         = 1'b1;
			res_a.kind     = fqd_pkg::KIND_END;
			res_a.out_byte = 8'h00;
			entry_count_d  = (entry_count_q == fqd_pkg::ENTRY_MAX) ?
				entry_count_q : entry_count_q + 16'd1;
			esc_d          = ESC_NONE;
			in_value_d     = 1'b0;
			entry_open_d   = 1'b0;
		end else begin
			entry_open_d = 1'b1;
			if (!in_value_q && (b == key_sep_q)) begin
				// name ends; a cut escape is dropped
				in_value_d = 1'b1;
				esc_d      = ESC_NONE;
			end else if (esc_q == ESC_HIGH) begin
				high_digit_d = b;
				esc_d        = ESC_LOW;
			end else if (esc_q == ESC_LOW) begin
				have_a         = 1'b1;
				res_a.out_byte = esc_byte;
				esc_d          = ESC_NONE;
			end else if (b == fqd_pkg::CHR_PLUS) begin
				have_a         = 1'b1;
				res_a.out_byte = fqd_pkg::CHR_SPACE;
			end else if (b == fqd_pkg::CHR_PCT) begin
				esc_d = ESC_HIGH;
			end else begin
				have_a = 1'b1;
			end
		end

		// End of stream closes an open entry and clears the part state
		if (item_s1.end_of_stream) begin
			if (entry_open_d) begin
				have_b             = 1'b1;
				res_b.entry_number = entry_count_d;
				entry_count_d      = (entry_count_d == fqd_pkg::ENTRY_MAX) ?
					entry_count_d : entry_count_d + 16'd1;
			end
			esc_d        = ESC_NONE;
			in_value_d   = 1'b0;
			entry_open_d = 1'b0;
		end
	end

	// Pack results in order; the final one carries last_of_run
	always_comb begin
		push.res0 = res_a;
		push.res1 = res_b;
		if (have_a && have_b) begin
			push.count = 2'd2;
		end else if (have_a) begin
			push.count = 2'd1;
			push.res0.last_of_run = 1'b1;
		end else if (have_b) begin
			push.count = 2'd1;
			push.res0  = res_b;
		end else begin
			push.count = 2'd0;
		end
	end

	// Decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q         <= ESC_NONE;
			high_digit_q  <= 8'h00;
			in_value_q    <= 1'b0;
			entry_open_q  <= 1'b0;
			entry_count_q <= 16'd0;
		end else if (advance) begin
			esc_q         <= esc_d;
			high_digit_q  <= high_digit_d;
			in_value_q    <= in_value_d;
			entry_open_q  <= entry_open_d;
			entry_count_q <= entry_count_d;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_sep_q <= fqd_pkg::PAIR_SEP_RESET;
			key_sep_q  <= fqd_pkg::KEY_SEP_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				fqd_pkg::CFG_PAIR_SEP: pair_sep_q <= cfg_data;
				fqd_pkg::CFG_KEY_SEP:  key_sep_q  <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

>>> hdl/fqd_out_fifo.sv
// ----------------------------------------------------------------------------
// fqd_out_fifo
// Result queue: takes up to two items per cycle, presents one item per cycle
// while result_stall is low on the valid/stall result channel.
// ----------------------------------------------------------------------------
module fqd_out_fifo #(
	parameter int Depth = fqd_pkg::FIFO_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_en,
	input  fqd_pkg::dec_push_t  push,
	output logic                room,
	output logic                result_valid,
	input  logic                result_stall,
	output fqd_pkg::out_item_t  result_item
);

	localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CNT_W = $clog2(Depth + 1);

	fqd_pkg::out_item_t mem_q [Depth];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] wr_ptr1;
	logic [PTR_W-1:0] wr_ptr2;
	logic [1:0]       n_push;
	logic             pop;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(Depth - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign n_push  = push_en ? push.count : 2'd0;
	assign wr_ptr1 = ptr_inc(wr_ptr_q);
	assign wr_ptr2 = ptr_inc(wr_ptr1);
	assign pop     = result_valid && !result_stall;

	assign room         = (count_q <= CNT_W'(Depth - 2));
	assign result_valid = (count_q != '0);
	assign result_item  = mem_q[rd_ptr_q];

	// Entry storage, one or two writes per cycle
	always_ff @(posedge clk) begin
		for (int i = 0; i < Depth; i++) begin
			if ((n_push != 2'd0) && (wr_ptr_q == PTR_W'(i))) begin
				mem_q[i] <= push.res0;
			end else if ((n_push == 2'd2) && (wr_ptr1 == PTR_W'(i))) begin
				mem_q[i] <= push.res1;
			end
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			case (n_push)
				2'd1:    wr_ptr_q <= wr_ptr1;
				2'd2:    wr_ptr_q <= wr_ptr2;
				default: wr_ptr_q <= wr_ptr_q;
			endcase
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			count_q <= count_q + CNT_W'(n_push) - CNT_W'(pop);
		end
	end

endmodule

>>> hdl/form_query_decoder_core.sv
// ----------------------------------------------------------------------------
// form_query_decoder_core
// Form query decoder: splits raw query bytes into entries and decodes them.
// ----------------------------------------------------------------------------
// Usage:
//   byte channel (byte_valid/byte_stall/byte_item): one raw byte per item,
//   with end_of_stream marking the last byte of a query string.
//   result channel (result_valid/result_stall/result_item): decoded name
//   bytes, value bytes and end-of-entry markers, zero to two per byte.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 sets the
//   pair separator, index 1 the key separator; cfg_ready is always high.
//   Write it only while the block is idle.
// Path: an accepted byte is held in the input register, then decoded into
//   the result queue, from which its results are offered.
// Throughput: one byte per cycle while the queue has room; a byte that
//   yields two results is offered as two items; the queue absorbs the extra.
// Stall: when the receiver stalls, the queue fills; once fewer than two
//   free entries remain, a pending input byte holds and byte_stall rises.
// Reset: separators return to '&' and '=', the entry counter and all
//   decode state clear, and the queue empties.
// ----------------------------------------------------------------------------
module form_query_decoder_core #(
	parameter int FifoDepth = fqd_pkg::FIFO_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           byte_valid,
	output logic                           byte_stall,
	input  fqd_pkg::in_item_t              byte_item,
	output logic                           result_valid,
	input  logic                           result_stall,
	output fqd_pkg::out_item_t             result_item,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [fqd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [7:0]                     cfg_data
);

	logic               valid_s1;
	fqd_pkg::in_item_t  item_s1;
	logic               room;
	logic               advance;
	fqd_pkg::dec_push_t push;

	assign cfg_ready  = 1'b1;
	assign advance    = valid_s1 && room;
	assign byte_stall = valid_s1 && !room;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			item_s1 <= byte_item;
		end
	end

	fqd_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_s1   (item_s1),
		.advance   (advance),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push)
	);

	fqd_out_fifo #(
		.Depth (FifoDepth)
	) u_out_fifo (
		.clk          (clk),
		.arst_n       (arst_n),
		.push_en      (advance),
		.push         (push),
		.room         (room),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item)
	);

endmodule

>>> hdl/fqd_checker.sv
// ----------------------------------------------------------------------------
// fqd_checker
// Port-level checks for the form query decoder, bound to the top level.
// ----------------------------------------------------------------------------
module fqd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               result_valid,
	input logic               result_stall,
	input fqd_pkg::out_item_t result_item
);

	// A stalled result item holds
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result_item))
		else $error("stalled result item changed");

	// Result valid drops only after an item was taken
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(result_valid) |-> $past(!result_stall))
		else $error("result valid dropped without acceptance");

	// End of entry carries no byte and always closes the run of its byte
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result_item.kind == fqd_pkg::KIND_END) |->
		result_item.last_of_run && (result_item.out_byte == 8'h00))
		else $error("malformed end of entry item");

	// A byte result not last in its run is followed at once by the end of
	// the same entry
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && !result_item.last_of_run |=>
		result_valid && (result_item.kind == fqd_pkg::KIND_END) &&
		(result_item.entry_number == $past(result_item.entry_number)))
		else $error("second result of a byte missing or wrong");

endmodule

bind form_query_decoder_core fqd_checker u_fqd_checker (.*);
